FILE: sv/twdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twdq_pkg
// shared types, constants and the half widening function
// ----------------------------------------------------------------------------
package twdq_pkg;

    localparam int BLOCK_ELEMENTS = 32;

    localparam logic [1:0] FMT_F32 = 2'd0;
    localparam logic [1:0] FMT_F16 = 2'd1;
    localparam logic [1:0] FMT_Q8  = 2'd2;

    localparam logic       REG_FORMAT = 1'b0;
    localparam logic       REG_COUNT  = 1'b1;

    localparam logic [31:0] F32_INF  = 32'h7F80_0000;
    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

    typedef struct packed {
        logic        is_q8;
        logic [15:0] scale;
        logic [31:0] word;
    } t_conv_req;

    // half to single, subnormals normalised
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  ex;
        logic [9:0]  frac;
        logic [3:0]  top;
        logic [9:0]  sh;
        logic [31:0] res;
        sgn  = {h[15], 31'd0};
        ex   = h[14:10];
        frac = h[9:0];
        top  = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (frac[i]) begin
                top = 4'(i);
            end
        end
        sh = frac << (4'd10 - top);
        if (ex == 5'd0) begin
            if (frac == 10'd0) begin
                res = sgn;
            end else begin
                res = sgn | {1'b0, 8'(top) + 8'd103, sh, 13'd0};
            end
        end else if (ex == 5'h1F) begin
            res = sgn | F32_INF | {9'd0, frac, 13'd0};
        end else begin
            res = sgn | {1'b0, 8'(ex) + 8'd112, frac, 13'd0};
        end
        return res;
    endfunction

endpackage

FILE: sv/twdq_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twdq_convert
// combinational element conversion: passthrough, half widening, scale product
// ----------------------------------------------------------------------------
module twdq_convert (
    input  twdq_pkg::t_conv_req i_req,
    output logic [31:0]         o_value
);

    logic [31:0] s;
    logic [31:0] w;
    logic        neg;
    logic [7:0]  mag;
    logic [31:0] sgn;
    logic [7:0]  ex;
    logic [31:0] prod;
    logic [2:0]  top;
    logic [31:0] shp;

    always_comb begin
        s    = twdq_pkg::widen_half(i_req.scale);
        w    = twdq_pkg::widen_half(i_req.word[15:0]);
        neg  = i_req.word[7];
        mag  = neg ? (8'd0 - i_req.word[7:0]) : i_req.word[7:0];
        sgn  = {s[31] ^ neg, 31'd0};
        ex   = s[30:23];
        prod = {1'b1, s[22:0]} * {24'd0, mag};
        // mag at most 128 so product grows at most 7 bits over the mantissa
        top  = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (prod[23 + i]) begin
                top = 3'(i);
            end
        end
        shp = prod >> top;
        if (!i_req.is_q8) begin
            o_value = i_req.word;
        end else if (ex == 8'hFF) begin
            if (s[22:0] != 23'd0) begin
                o_value = s | 32'h0040_0000;
            end else if (mag == 8'd0) begin
                o_value = twdq_pkg::F32_QNAN;
            end else begin
                o_value = sgn | twdq_pkg::F32_INF;
            end
        end else if (s[30:0] == 31'd0 || mag == 8'd0) begin
            o_value = sgn;
        end else begin
            o_value = sgn | {1'b0, ex + 8'(top), shp[22:0]};
        end
        if (i_req.is_q8 == 1'b0 && i_req.scale[0] == 1'b1) begin
            o_value = w;
        end
    end

endmodule

FILE: sv/tensor_weight_dequantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_weight_dequantizer
// byte stream of f32, f16 or q8_0 tensor data to single precision words
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in      | input     | valid / stall    | i_data_byte
// out     | output    | valid / stall    | o_value_bits, o_last_element
// cfg     | input     | valid / ready    | i_cfg_index, i_cfg_data
//
// one byte is taken per cycle unless o_stall is high; a result appears in
// the cycle after the byte that completes an element, in the output register.
// input stall is raised only while a result waits and the output is stalled.
// reset is synchronous and returns the stream position to its start.
// ----------------------------------------------------------------------------
module tensor_weight_dequantizer #(
    parameter int BLOCK_ELEMENTS = twdq_pkg::BLOCK_ELEMENTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value_bits,
    output logic        o_last_element,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int PW = $clog2(BLOCK_ELEMENTS + 2);
    localparam logic [PW-1:0] BLOCK_END = PW'(BLOCK_ELEMENTS + 1);

    logic [1:0]    r_fmt;
    logic [31:0]   r_cnt;
    logic [PW-1:0] r_phase;
    logic [23:0]   r_part;
    logic [15:0]   r_scale;
    logic [31:0]   r_done;
    logic          r_ovalid;
    logic [31:0]   r_value;
    logic          r_last;

    logic          accept;
    logic          cfg_we;
    logic [31:0]   cnt;
    logic [1:0]    fmt;
    logic          fire;
    logic          n_last;
    logic [31:0]   done_inc;
    twdq_pkg::t_conv_req req;
    logic [31:0]   conv_value;

    assign o_stall     = r_ovalid & i_stall;
    assign accept      = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign cnt         = (r_cnt == 32'd0) ? 32'd1 : r_cnt;
    assign fmt         = (r_fmt == 2'd3) ? twdq_pkg::FMT_F32 : r_fmt;
    assign done_inc    = r_done + 32'd1;

    always_comb begin
        req.is_q8 = 1'b0;
        req.scale = 16'd0;
        req.word  = {i_data_byte, r_part};
        fire      = 1'b0;
        n_last    = 1'b0;
        case (fmt)
            twdq_pkg::FMT_Q8: begin
                req.is_q8 = 1'b1;
                req.scale = r_scale;
                req.word  = {24'd0, i_data_byte};
                fire      = (r_phase >= PW'(2)) && (r_done < cnt);
                n_last    = done_inc == cnt;
            end
            twdq_pkg::FMT_F16: begin
                // scale bit 0 selects half widening inside the converter
                req.scale = 16'd1;
                req.word  = {16'd0, i_data_byte, r_part[7:0]};
                fire      = r_phase[0];
                n_last    = done_inc >= cnt;
            end
            default: begin
                fire   = r_phase[1:0] == 2'd3;
                n_last = done_inc >= cnt;
            end
        endcase
    end

    twdq_convert u_conv (
        .i_req   (req),
        .o_value (conv_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= twdq_pkg::FMT_F32;
            r_cnt    <= 32'd1;
            r_phase  <= '0;
            r_part   <= '0;
            r_scale  <= '0;
            r_done   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_we) begin
                if (i_cfg_index == twdq_pkg::REG_FORMAT) begin
                    r_fmt <= i_cfg_data[1:0];
                end else begin
                    r_cnt <= i_cfg_data;
                end
                r_phase <= '0;
                r_part  <= '0;
                r_scale <= '0;
                r_done  <= '0;
            end else if (accept) begin
                if (fire) begin
                    r_ovalid <= 1'b1;
                    r_value  <= conv_value;
                    r_last   <= n_last;
                end
                if (fmt == twdq_pkg::FMT_Q8) begin
                    if (r_phase == PW'(0)) begin
                        r_scale <= {8'd0, i_data_byte};
                        r_phase <= PW'(1);
                    end else if (r_phase == PW'(1)) begin
                        r_scale <= {i_data_byte, r_scale[7:0]};
                        r_phase <= PW'(2);
                    end else begin
                        if (r_phase == BLOCK_END) begin
                            r_phase <= '0;
                            if (fire ? (done_inc >= cnt) : (r_done >= cnt)) begin
                                r_done <= '0;
                            end else if (fire) begin
                                r_done <= done_inc;
                            end
                        end else begin
                            r_phase <= r_phase + PW'(1);
                            if (fire) begin
                                r_done <= done_inc;
                            end
                        end
                    end
                end else if (fire) begin
                    r_phase <= '0;
                    r_part  <= '0;
                    r_done  <= n_last ? 32'd0 : done_inc;
                end else begin
                    case (r_phase[1:0])
                        2'd0:    r_part[7:0]   <= i_data_byte;
                        2'd1:    r_part[15:8]  <= i_data_byte;
                        default: r_part[23:16] <= i_data_byte;
                    endcase
                    r_phase <= {{(PW-2){1'b0}}, r_phase[1:0] + 2'd1};
                end
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_value_bits   = r_value;
    assign o_last_element = r_last;

endmodule
